>>> rtl/assert_macros.svh
// Assertion macros used by the slot allocator datapath (sadr_dp).
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge out of reset.
`define SADR_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("slot allocator assertion failed");

// Trigger in one cycle implies consequence in the next.
`define SADR_ASSERT_NEXT(lbl, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("slot allocator assertion failed");

`endif

>>> rtl/sadr_pkg.sv
// Shared types and constants for the slot allocator with deferred release.
// No dependencies; imported by sadr_ctrl, sadr_dp and the top level.
`default_nettype none

package sadr_pkg;

	localparam int KIND_W    = 3;
	localparam int KEY_W     = 32;
	localparam int SLOT_W    = 10;
	localparam int CAP_W     = 11;
	localparam int STATUS_W  = 3;
	localparam int DRAINED_W = 11;

	// slot count; the slot, capacity and drained widths are sized for it
	localparam int SLOTS     = 1024;

	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BIND    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DELETED = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CHANGED = 3'd4;
	localparam logic [KIND_W-1:0] KIND_DRAIN   = 3'd5;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_LIST_OVF   = 3'd4;

	typedef struct packed {
		logic              vld;
		logic [KEY_W-1:0]  key;
		logic [SLOT_W-1:0] slot;
	} tbl_entry_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic alloc;
		logic pop_take;
		logic release_op;
		logic scan_start;
		logic scan_run;
		logic apply;
		logic drain_start;
		logic drain_rd;
		logic drain_wr;
		logic drain_end;
		logic clear_step;
		logic load_out;
	} sadr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              free_nonempty;
		logic              scan_done;
		logic              pend_empty;
		logic              drain_last;
		logic              clear_last;
	} sadr_sts_t;

endpackage

`default_nettype wire

>>> rtl/sadr_dp.sv
// Datapath: counters, free stack, pending list, key table and result registers.
// Depends on sadr_pkg and assert_macros.svh; driven by sadr_ctrl.
`default_nettype none
`include "assert_macros.svh"

module sadr_dp
	import sadr_pkg::*;
#(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CAP_W-1:0]     cfg_wdata,
	input  wire logic [KIND_W-1:0]    kind,
	input  wire logic [KEY_W-1:0]     key,
	input  wire logic [SLOT_W-1:0]    slot_index,
	input  wire logic                 engine_backed,
	input  wire logic                 same_size,
	input  wire sadr_cmd_t            cmd,
	output sadr_sts_t                 sts,
	output logic [STATUS_W-1:0]       status,
	output logic [SLOT_W-1:0]         granted_index,
	output logic                      retired,
	output logic [DRAINED_W-1:0]      drained_count
);

	localparam int SW  = $clog2(SLOTS);
	localparam int CW  = $clog2(SLOTS + 1);
	localparam int TAW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int EW  = (CW > CAP_W) ? CW : CAP_W;

	// configuration and counters
	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0]    free_cnt_q;
	logic [CW-1:0]    pend_cnt_q;
	logic [CW-1:0]    next_fresh_q;
	logic [CW-1:0]    drain_idx_q;
	logic [TAW-1:0]   clr_idx_q;

	// captured item
	logic [KIND_W-1:0] kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [SLOT_W-1:0] slot_q;
	logic              eb_q;
	logic              ss_q;

	// working result
	logic [STATUS_W-1:0] res_status_q;
	logic [SLOT_W-1:0]   res_granted_q;
	logic                res_retired_q;
	logic [CW-1:0]       res_drained_q;

	// output register
	logic [STATUS_W-1:0]  out_status_q;
	logic [SLOT_W-1:0]    out_granted_q;
	logic                 out_retired_q;
	logic [DRAINED_W-1:0] out_drained_q;

	// table scan
	logic [TAW-1:0]    scan_q;
	logic [TAW-1:0]    rd_idx_s1;
	logic              rd_vld_s1;
	logic              hit_q;
	logic [TAW-1:0]    hit_idx_q;
	logic [SLOT_W-1:0] hit_slot_q;
	logic              free_found_q;
	logic [TAW-1:0]    free_idx_q;

	// memories
	tbl_entry_t        tbl_mem [TABLE_ENTRIES];
	tbl_entry_t        tbl_rd_q;
	logic [SLOT_W-1:0] free_mem [SLOTS];
	logic [SLOT_W-1:0] free_rd_q;
	logic [SLOT_W-1:0] pend_mem [SLOTS];
	logic [SLOT_W-1:0] pend_rd_q;

	logic                free_nonempty;
	logic                free_room;
	logic                pend_room;
	logic                fresh_ok;
	logic [EW-1:0]       cap_ext;
	logic [EW-1:0]       cap_eff;
	logic                hit_now;
	logic                free_now;
	logic                free_we;
	logic [SW-1:0]       free_wa;
	logic [SLOT_W-1:0]   free_wd;
	logic [SW-1:0]       free_ra;
	logic                tbl_we;
	logic [TAW-1:0]      tbl_wa;
	tbl_entry_t          tbl_wd;
	logic                pend_we;
	logic [STATUS_W-1:0] ap_status;
	logic [SLOT_W-1:0]   ap_granted;
	logic                ap_retired;

	assign free_nonempty = (free_cnt_q != '0);
	assign free_room     = (free_cnt_q != CW'(SLOTS));
	assign pend_room     = (pend_cnt_q != CW'(SLOTS));

	// effective capacity is the smaller of the register and the stack depth
	assign cap_ext  = EW'(cap_q);
	assign cap_eff  = (cap_ext < EW'(SLOTS)) ? cap_ext : EW'(SLOTS);
	assign fresh_ok = (EW'(next_fresh_q) < cap_eff);

	assign hit_now  = rd_vld_s1 && tbl_rd_q.vld && (tbl_rd_q.key == key_q);
	assign free_now = rd_vld_s1 && !tbl_rd_q.vld;

	assign free_ra = SW'(free_cnt_q - CW'(1));

	assign sts.kind          = kind_q;
	assign sts.free_nonempty = free_nonempty;
	assign sts.scan_done     = hit_now || (rd_vld_s1 && (rd_idx_s1 == TAW'(TABLE_ENTRIES - 1)));
	assign sts.pend_empty    = (pend_cnt_q == '0);
	assign sts.drain_last    = ((drain_idx_q + CW'(1)) == pend_cnt_q);
	assign sts.clear_last    = (clr_idx_q == TAW'(TABLE_ENTRIES - 1));

	// free stack write: release or drain push
	always_comb begin
		free_we = 1'b0;
		free_wa = free_cnt_q[SW-1:0];
		free_wd = slot_q;
		if (cmd.release_op && free_room) begin
			free_we = 1'b1;
		end
		if (cmd.drain_wr && free_room) begin
			free_we = 1'b1;
			free_wd = pend_rd_q;
		end
	end

	// table clear and post-scan update, retire onto pending list
	always_comb begin
		tbl_we     = 1'b0;
		tbl_wa     = clr_idx_q;
		tbl_wd     = '0;
		pend_we    = 1'b0;
		ap_status  = ST_OK;
		ap_granted = '0;
		ap_retired = 1'b0;
		if (cmd.clear_step) begin
			tbl_we = 1'b1;
		end
		if (cmd.apply) begin
			case (kind_q)
				KIND_BIND: begin
					tbl_wd = '{vld: 1'b1, key: key_q, slot: slot_q};
					if (hit_q) begin
						tbl_we = 1'b1;
						tbl_wa = hit_idx_q;
					end else if (free_found_q) begin
						tbl_we = 1'b1;
						tbl_wa = free_idx_q;
					end else begin
						ap_status = ST_TABLE_FULL;
					end
				end
				KIND_DELETED, KIND_CHANGED: begin
					if (!hit_q) begin
						ap_status = ST_NOT_FOUND;
					end else if (!(kind_q == KIND_CHANGED && (eb_q || ss_q))) begin
						tbl_we     = 1'b1;
						tbl_wa     = hit_idx_q;
						ap_granted = hit_slot_q;
						if (pend_room) begin
							pend_we    = 1'b1;
							ap_retired = 1'b1;
						end else begin
							ap_status = ST_LIST_OVF;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= CAP_RESET;
			free_cnt_q   <= '0;
			pend_cnt_q   <= '0;
			next_fresh_q <= '0;
			drain_idx_q  <= '0;
			clr_idx_q    <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.clear_step) begin
				clr_idx_q <= clr_idx_q + TAW'(1);
			end
			if (cmd.alloc) begin
				if (free_nonempty) begin
					free_cnt_q <= free_cnt_q - CW'(1);
				end else if (fresh_ok) begin
					next_fresh_q <= next_fresh_q + CW'(1);
				end
			end
			if ((cmd.release_op || cmd.drain_wr) && free_room) begin
				free_cnt_q <= free_cnt_q + CW'(1);
			end
			if (pend_we) begin
				pend_cnt_q <= pend_cnt_q + CW'(1);
			end
			if (cmd.drain_start) begin
				drain_idx_q <= '0;
			end else if (cmd.drain_wr) begin
				drain_idx_q <= drain_idx_q + CW'(1);
			end
			if (cmd.drain_end) begin
				pend_cnt_q <= '0;
			end
		end
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '0;
			rd_vld_s1    <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.scan_start) begin
			scan_q       <= '0;
			rd_vld_s1    <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_run;
			if (cmd.scan_run) begin
				scan_q <= scan_q + TAW'(1);
				if (hit_now) begin
					hit_q <= 1'b1;
				end
				if (free_now) begin
					free_found_q <= 1'b1;
				end
			end
		end
	end

	// scan payload: index in flight, first free entry, matched entry
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q;
		if (cmd.scan_run && hit_now) begin
			hit_idx_q  <= rd_idx_s1;
			hit_slot_q <= tbl_rd_q.slot;
		end
		if (cmd.scan_run && free_now && !free_found_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

	// item capture and working result
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q        <= kind;
			key_q         <= key;
			slot_q        <= slot_index;
			eb_q          <= engine_backed;
			ss_q          <= same_size;
			res_status_q  <= ST_OK;
			res_granted_q <= '0;
			res_retired_q <= 1'b0;
			res_drained_q <= '0;
		end else begin
			if (cmd.alloc && !free_nonempty) begin
				if (fresh_ok) begin
					res_granted_q <= SLOT_W'(next_fresh_q);
				end else begin
					res_status_q <= ST_EXHAUSTED;
				end
			end
			if (cmd.pop_take) begin
				res_granted_q <= free_rd_q;
			end
			if (cmd.release_op && !free_room) begin
				res_status_q <= ST_LIST_OVF;
			end
			if (cmd.apply) begin
				res_status_q  <= ap_status;
				res_granted_q <= ap_granted;
				res_retired_q <= ap_retired;
			end
			if (cmd.drain_wr) begin
				if (free_room) begin
					res_drained_q <= res_drained_q + CW'(1);
				end else begin
					res_status_q <= ST_LIST_OVF;
				end
			end
		end
		if (cmd.load_out) begin
			out_status_q  <= res_status_q;
			out_granted_q <= res_granted_q;
			out_retired_q <= res_retired_q;
			out_drained_q <= DRAINED_W'(res_drained_q);
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_wa] <= tbl_wd;
		end
		tbl_rd_q <= tbl_mem[scan_q];
	end

	always_ff @(posedge clk) begin
		if (free_we) begin
			free_mem[free_wa] <= free_wd;
		end
		if (cmd.alloc) begin
			free_rd_q <= free_mem[free_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (pend_we) begin
			pend_mem[pend_cnt_q[SW-1:0]] <= hit_slot_q;
		end
		if (cmd.drain_rd) begin
			pend_rd_q <= pend_mem[drain_idx_q[SW-1:0]];
		end
	end

	assign status        = out_status_q;
	assign granted_index = out_granted_q;
	assign retired       = out_retired_q;
	assign drained_count = out_drained_q;

	`SADR_ASSERT(a_free_bound, free_cnt_q <= CW'(SLOTS))
	`SADR_ASSERT(a_pend_bound, pend_cnt_q <= CW'(SLOTS))
	`SADR_ASSERT(a_fresh_bound, next_fresh_q <= CW'(SLOTS))
	`SADR_ASSERT_NEXT(a_drain_empties, cmd.drain_end, pend_cnt_q == '0)

endmodule

`default_nettype wire

>>> rtl/sadr_ctrl.sv
// Controller state machine: item handshake, operation sequencing, result handshake.
// Depends on sadr_pkg; commands sadr_dp through sadr_cmd_t.
`default_nettype none

module sadr_ctrl
	import sadr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	output logic           item_stall,
	output logic           result_valid,
	input  wire logic      result_stall,
	input  wire sadr_sts_t sts,
	output sadr_cmd_t      cmd
);

	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_EXEC     = 4'd2;
	localparam logic [3:0] S_POP      = 4'd3;
	localparam logic [3:0] S_SCAN     = 4'd4;
	localparam logic [3:0] S_APPLY    = 4'd5;
	localparam logic [3:0] S_DRAIN_RD = 4'd6;
	localparam logic [3:0] S_DRAIN_WR = 4'd7;
	localparam logic [3:0] S_DONE     = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign out_free   = !out_valid_q || !result_stall;
	assign item_stall = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_EXEC;
				end
			end
			S_EXEC: begin
				case (sts.kind)
					KIND_ALLOC: begin
						cmd.alloc = 1'b1;
						state_nxt = sts.free_nonempty ? S_POP : S_DONE;
					end
					KIND_RELEASE: begin
						cmd.release_op = 1'b1;
						state_nxt      = S_DONE;
					end
					KIND_BIND, KIND_DELETED, KIND_CHANGED: begin
						cmd.scan_start = 1'b1;
						state_nxt      = S_SCAN;
					end
					KIND_DRAIN: begin
						cmd.drain_start = 1'b1;
						state_nxt       = sts.pend_empty ? S_DONE : S_DRAIN_RD;
					end
					default: begin
						state_nxt = S_DONE;
					end
				endcase
			end
			S_POP: begin
				cmd.pop_take = 1'b1;
				state_nxt    = S_DONE;
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_nxt = S_APPLY;
				end
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_nxt = S_DONE;
			end
			S_DRAIN_RD: begin
				cmd.drain_rd = 1'b1;
				state_nxt    = S_DRAIN_WR;
			end
			S_DRAIN_WR: begin
				cmd.drain_wr = 1'b1;
				if (sts.drain_last) begin
					cmd.drain_end = 1'b1;
					state_nxt     = S_DONE;
				end else begin
					state_nxt = S_DRAIN_RD;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/slot_allocator_deferred_release.sv
// Top level of the slot allocator with deferred release.
// Depends on sadr_pkg, sadr_ctrl and sadr_dp.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------------
//  item     | item_valid / item_stall    | kind, key, slot_index, engine_backed, same_size
//  result   | result_valid / result_stall| status, granted_index, retired, drained_count
//  config   | cfg_we                     | cfg_wdata (capacity_in_use)
//
// One item at a time. Release and fresh allocate pass through S_EXEC and S_DONE; a pop
// from the free stack adds S_POP, set by the registered read of the stack memory.
// Bind, delete and change: S_SCAN, one key table entry read per cycle, then S_APPLY.
// Drain: one pending-list read then one free-stack write per slot.
// After reset the key table is swept clear with item_stall high.
// A held result_stall keeps the finished result; one more transaction is taken and run,
// then item_stall stays high until the waiting result is taken.
`default_nettype none

module slot_allocator_deferred_release
	import sadr_pkg::*;
#(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CAP_W-1:0]     cfg_wdata,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire logic [KIND_W-1:0]    kind,
	input  wire logic [KEY_W-1:0]     key,
	input  wire logic [SLOT_W-1:0]    slot_index,
	input  wire logic                 engine_backed,
	input  wire logic                 same_size,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic [STATUS_W-1:0]       status,
	output logic [SLOT_W-1:0]         granted_index,
	output logic                      retired,
	output logic [DRAINED_W-1:0]      drained_count
);

	sadr_cmd_t cmd;
	sadr_sts_t sts;

	sadr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	sadr_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.kind          (kind),
		.key           (key),
		.slot_index    (slot_index),
		.engine_backed (engine_backed),
		.same_size     (same_size),
		.cmd           (cmd),
		.sts           (sts),
		.status        (status),
		.granted_index (granted_index),
		.retired       (retired),
		.drained_count (drained_count)
	);

endmodule

`default_nettype wire
